[src/keypad_code_lock_assert.svh]
// assertion macros shared by the keypad lock rtl
// clocked on clock, disabled while reset is high
`ifndef KEYPAD_CODE_LOCK_ASSERT_SVH
`define KEYPAD_CODE_LOCK_ASSERT_SVH

// same-cycle implication
`define KCL_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("keypad lock: same-cycle check failed");

// next-cycle implication
`define KCL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("keypad lock: next-cycle check failed");

`endif

[src/kcl_pkg.sv]
// shared types and constants of the keypad code lock
// no dependencies
`default_nettype none

package kcl_pkg;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   localparam logic [7:0]  KEY_VALIDATE     = 8'd35;   // '#'
   localparam logic [7:0]  FILL_CHAR        = 8'd120;  // 'x'
   localparam logic [5:0]  WRONG_MAX        = 6'd63;
   localparam logic [9:0]  TICKS_PER_SECOND = 10'd1000;
   localparam int          CODE_CHARS       = 8;       // characters held in code_value

   localparam logic [3:0]  RST_CODE_LENGTH   = 4'd4;
   localparam logic [5:0]  RST_MAX_ERRORS    = 6'd3;
   localparam logic [8:0]  RST_LOCKOUT_S     = 9'd30;
   localparam logic [18:0] RST_LOCKOUT_TICKS = 19'd30000;
   localparam logic [15:0] RST_DISPLAY_MS    = 16'd1100;

   typedef enum logic [2:0] {
      REG_CODE_LENGTH  = 3'd0,
      REG_CODE_VALUE   = 3'd1,
      REG_MAX_ERRORS   = 3'd2,
      REG_LOCKOUT_S    = 3'd3,
      REG_DISPLAY_MS   = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_OPEN   = 2'd0,
      ST_CLOSED = 2'd1,
      ST_ERROR  = 2'd2,
      ST_LOCKED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_KEY     = 2'd1,
      EV_CORRECT = 2'd2,
      EV_WRONG   = 2'd3
   } event_type;

   typedef enum logic {
      OP_KEY  = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef struct packed {
      logic [3:0]  code_length;
      logic [63:0] code_value;
      logic [5:0]  max_errors;
      logic [18:0] lockout_ticks;
      logic [15:0] error_display_ms;
   } cfg_type;

   typedef struct packed {
      logic       shift;
      logic       fill;
      logic [7:0] key;
   } cell_ctl_type;

   // first member sits in the top bits, so lock_status lands lowest
   typedef struct packed {
      event_type  event_res;
      logic [5:0] error_count;
      status_type lock_status;
   } rsp_item_type;

endpackage

`default_nettype wire

[src/kcl_cell.sv]
// one entry position of the keypad lock: holds a character, shifts it
// towards position zero and extends the code match chain; uses kcl_pkg
`default_nettype none

module kcl_cell #(
   parameter int LEN_W = 4,
   parameter int IDX   = 0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire kcl_pkg::cell_ctl_type ctl,
   input  wire logic [LEN_W-1:0]   eff_len,
   input  wire logic [7:0]         next_char,
   input  wire logic [7:0]         exp_char,
   input  wire logic               ok_in,
   output      logic [7:0]         char_out,
   output      logic               ok_out
);
   import kcl_pkg::*;

   localparam logic [LEN_W-1:0] POS      = LEN_W'(IDX);
   localparam logic [LEN_W-1:0] POS_NEXT = LEN_W'(IDX + 1);

   logic [7:0] char_ff, char_in;
   logic       active;

   assign active = POS < eff_len;

   always_comb begin
      char_in = char_ff;
      if (ctl.fill) begin
         char_in = FILL_CHAR;
      end else if (ctl.shift) begin
         if (POS_NEXT < eff_len) begin
            char_in = next_char;
         end else if (POS_NEXT == eff_len) begin
            char_in = ctl.key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_ff <= FILL_CHAR;
      end else begin
         char_ff <= char_in;
      end
   end

   // positions past the code length always match
   assign ok_out   = ok_in & (!active | (char_ff == exp_char));
   assign char_out = char_ff;

endmodule

`default_nettype wire

[src/kcl_csr.sv]
// register file of the keypad lock behind the csr port
// uses kcl_pkg
`default_nettype none

module kcl_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [kcl_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [kcl_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output      logic [kcl_pkg::CSR_DATA_W-1:0] csr_prdata,
   output      logic                           csr_pready,
   output      kcl_pkg::cfg_type               cfg
);
   import kcl_pkg::*;

   logic [3:0]  code_length_ff;
   logic [63:0] code_value_ff;
   logic [5:0]  max_errors_ff;
   logic [8:0]  lockout_s_ff;
   logic [18:0] lockout_ticks_ff;
   logic [15:0] display_ms_ff;
   logic        wr_en;
   reg_index_type idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign idx        = reg_index_type'(csr_paddr[CSR_ADDR_W-1:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         code_length_ff   <= RST_CODE_LENGTH;
         code_value_ff    <= '0;
         max_errors_ff    <= RST_MAX_ERRORS;
         lockout_s_ff     <= RST_LOCKOUT_S;
         lockout_ticks_ff <= RST_LOCKOUT_TICKS;
         display_ms_ff    <= RST_DISPLAY_MS;
      end else if (wr_en) begin
         case (idx)
            REG_CODE_LENGTH: code_length_ff <= csr_pwdata[3:0];
            REG_CODE_VALUE:  code_value_ff  <= csr_pwdata;
            REG_MAX_ERRORS:  max_errors_ff  <= csr_pwdata[5:0];
            REG_LOCKOUT_S: begin
               lockout_s_ff     <= csr_pwdata[8:0];
               // seconds to ticks once, at write time
               lockout_ticks_ff <= 19'(csr_pwdata[8:0]) * 19'(TICKS_PER_SECOND);
            end
            REG_DISPLAY_MS:  display_ms_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_CODE_LENGTH: csr_prdata = 64'(code_length_ff);
         REG_CODE_VALUE:  csr_prdata = code_value_ff;
         REG_MAX_ERRORS:  csr_prdata = 64'(max_errors_ff);
         REG_LOCKOUT_S:   csr_prdata = 64'(lockout_s_ff);
         REG_DISPLAY_MS:  csr_prdata = 64'(display_ms_ff);
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg.code_length      = code_length_ff;
   assign cfg.code_value       = code_value_ff;
   assign cfg.max_errors       = max_errors_ff;
   assign cfg.lockout_ticks    = lockout_ticks_ff;
   assign cfg.error_display_ms = display_ms_ff;

endmodule

`default_nettype wire

[src/kcl_outq.sv]
// two-word result queue: output register plus skid word
// uses kcl_pkg
`default_nettype none

module kcl_outq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire kcl_pkg::rsp_item_type push_item,
   output      logic                  can_push,
   output      logic                  out_valid,
   input  wire logic                  out_ready,
   output      kcl_pkg::rsp_item_type out_item
);
   import kcl_pkg::*;

   rsp_item_type head_ff, head_in, tail_ff, tail_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign pop       = out_valid & out_ready;
   assign can_push  = count_ff != 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign out_item  = head_ff;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      unique case (count_ff)
         2'd0: begin
            if (push) begin
               head_in  = push_item;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               head_in = push_item;
            end else if (push) begin
               tail_in  = push_item;
               count_in = 2'd2;
            end else if (pop) begin
               count_in = 2'd0;
            end
         end
         2'd2: begin
            if (pop) begin
               head_in  = tail_ff;
               count_in = 2'd1;
            end
         end
         default: count_in = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

`default_nettype wire

[src/keypad_code_lock.sv]
// keypad code lock top level: lock control, entry cell row, registers
// depends on kcl_pkg, kcl_cell, kcl_csr, kcl_outq, keypad_code_lock_assert.svh
//
//   channel   dir   handshake              payload
//   req_      in    tvalid/tready          tuser operation, tdata key_char
//   rsp_      out   tvalid/tready          tdata lock_status, error_count, event_res
//   csr_      in    psel/penable/pready    64-bit registers at 8-byte spacing
//
// one word per cycle unless req_tready is low: a word is decided in the cycle it is
// taken and its result is registered in a two-word output queue
// the code compare runs down the row of entry cells, one position each
// req_tready drops only while both queue words are waiting
// reset is synchronous; no clearing pass
`default_nettype none

module keypad_code_lock #(
   parameter int CODE_MAX_LEN = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output      logic                           req_tready,
   input  wire logic [7:0]                     req_tdata,   // [7:0] key_char
   input  wire logic [0:0]                     req_tuser,   // [0] operation
   output      logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [1:0] lock_status, [7:2] error_count, [9:8] event_res, rest zero
   output      logic [15:0]                    rsp_tdata,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [kcl_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [kcl_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output      logic [kcl_pkg::CSR_DATA_W-1:0] csr_prdata,
   output      logic                           csr_pready
);
   import kcl_pkg::*;

   localparam int LEN_W = $clog2(CODE_MAX_LEN + 1);

   cfg_type      cfg;
   cell_ctl_type cell_ctl;
   rsp_item_type rsp_item, q_item;

   status_type   status_ff, status_in;
   logic         prior_ff, prior_in;
   logic [5:0]   wrong_ff, wrong_in;
   logic [18:0]  timer_ff, timer_in, timer_inc;
   event_type    ev;

   logic [LEN_W-1:0] eff_len;
   logic [7:0]       cell_char [CODE_MAX_LEN];
   logic [7:0]       exp_char  [CODE_MAX_LEN];
   logic             cell_ok   [CODE_MAX_LEN+1];

   logic accept, is_tick, is_key, is_hash, entry_on, code_ok;
   logic disp_done, lock_done;

   kcl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // clamp the code length into 1..CODE_MAX_LEN
   always_comb begin
      if (cfg.code_length == 4'd0) begin
         eff_len = LEN_W'(1);
      end else if (5'(cfg.code_length) > 5'(CODE_MAX_LEN)) begin
         eff_len = LEN_W'(CODE_MAX_LEN);
      end else begin
         eff_len = LEN_W'(cfg.code_length);
      end
   end

   assign cell_ok[CODE_MAX_LEN] = 1'b1;

   for (genvar i = 0; i < CODE_MAX_LEN; i++) begin : g_cell
      logic [7:0] next_char;
      if (i < CODE_CHARS) begin : g_exp
         assign exp_char[i] = cfg.code_value[8*i +: 8];
      end else begin : g_exp_zero
         assign exp_char[i] = 8'd0;
      end
      if (i == CODE_MAX_LEN - 1) begin : g_end
         assign next_char = FILL_CHAR;
      end else begin : g_mid
         assign next_char = cell_char[i+1];
      end
      kcl_cell #(
         .LEN_W (LEN_W),
         .IDX   (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl),
         .eff_len   (eff_len),
         .next_char (next_char),
         .exp_char  (exp_char[i]),
         .ok_in     (cell_ok[i+1]),
         .char_out  (cell_char[i]),
         .ok_out    (cell_ok[i])
      );
   end

   assign code_ok   = cell_ok[0];
   assign accept    = req_tvalid & req_tready;
   assign is_tick   = req_tuser[0] == OP_TICK;
   assign entry_on  = (status_ff == ST_OPEN) | (status_ff == ST_CLOSED);
   assign is_key    = accept & !is_tick & entry_on;
   assign is_hash   = req_tdata == KEY_VALIDATE;
   assign timer_inc = timer_ff + 19'd1;
   assign disp_done = timer_inc >= 19'(cfg.error_display_ms);
   assign lock_done = timer_inc >= cfg.lockout_ticks;

   // next state
   always_comb begin
      status_in = status_ff;
      prior_in  = prior_ff;
      wrong_in  = wrong_ff;
      timer_in  = timer_ff;
      if (is_key && is_hash) begin
         if (code_ok) begin
            status_in = (status_ff == ST_OPEN) ? ST_CLOSED : ST_OPEN;
            wrong_in  = 6'd0;
         end else begin
            if (wrong_ff != WRONG_MAX) begin
               wrong_in = wrong_ff + 6'd1;
            end
            prior_in  = status_ff[0];
            status_in = ST_ERROR;
            timer_in  = 19'd0;
         end
      end else if (accept && is_tick) begin
         unique case (status_ff)
            ST_ERROR: begin
               timer_in = timer_inc;
               if (disp_done) begin
                  timer_in  = 19'd0;
                  status_in = (wrong_ff >= cfg.max_errors) ? ST_LOCKED
                                                           : status_type'({1'b0, prior_ff});
               end
            end
            ST_LOCKED: begin
               timer_in = timer_inc;
               if (lock_done) begin
                  timer_in  = 19'd0;
                  status_in = status_type'({1'b0, prior_ff});
                  wrong_in  = 6'd0;
               end
            end
            ST_OPEN, ST_CLOSED: ;
         endcase
      end
   end

   // outputs of the control: event code and cell row commands
   always_comb begin
      ev           = EV_NONE;
      cell_ctl.shift = 1'b0;
      cell_ctl.fill  = 1'b0;
      cell_ctl.key   = req_tdata;
      if (is_key) begin
         if (!is_hash) begin
            ev             = EV_KEY;
            cell_ctl.shift = 1'b1;
         end else begin
            ev            = code_ok ? EV_CORRECT : EV_WRONG;
            cell_ctl.fill = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= ST_CLOSED;
         prior_ff  <= 1'b1;
         wrong_ff  <= 6'd0;
         timer_ff  <= 19'd0;
      end else begin
         status_ff <= status_in;
         prior_ff  <= prior_in;
         wrong_ff  <= wrong_in;
         timer_ff  <= timer_in;
      end
   end

   assign rsp_item.lock_status = status_in;
   assign rsp_item.error_count = wrong_in;
   assign rsp_item.event_res   = ev;

   kcl_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (rsp_item),
      .can_push  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (q_item)
   );

   assign rsp_tdata = {6'd0, q_item};

`include "keypad_code_lock_assert.svh"

   // timer only moves on a tick
   `KCL_ASSERT_NEXT(a_timer_hold, !(accept && is_tick), timer_ff == $past(timer_ff))
   // a correct code always clears the error count
   `KCL_ASSERT_NEXT(a_ok_clears, is_key && is_hash && code_ok, wrong_ff == 6'd0)
   // after any validation the entry row is refilled
   `KCL_ASSERT_NEXT(a_refill, is_key && is_hash, cell_char[0] == FILL_CHAR)
   // lockout is left only through a tick
   `KCL_ASSERT_NEXT(a_lock_hold, status_ff == ST_LOCKED && !(accept && is_tick),
                    status_ff == ST_LOCKED)

endmodule

`default_nettype wire

[sim/keypad_code_lock_test.sv]
// self-checking testbench of keypad_code_lock: keys and ticks in, one status word out
// per word, checked against a predictor of the lock kept in step with the stimulus
// depends on kcl_pkg and the keypad_code_lock rtl
module keypad_code_lock_test;
   timeunit 1ns;
   timeprecision 1ps;

   import kcl_pkg::*;

   localparam int CODE_LEN_MAX  = 8;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int RANDOM_WORDS  = 450;
   localparam int RANDOM_PHASES = 6;
   localparam int IDLE_PERCENT  = 27;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata   = '0;   // [7:0] key_char
   logic [0:0]            req_tuser   = '0;   // [0] operation
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [15:0]           rsp_tdata;          // [1:0] lock_status, [7:2] error_count, [9:8] event_res
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predictor copy of the registers
   logic [3:0]  cfg_code_length = RST_CODE_LENGTH;
   logic [63:0] cfg_code_value  = '0;
   logic [5:0]  cfg_max_errors  = RST_MAX_ERRORS;
   logic [8:0]  cfg_lockout_s   = RST_LOCKOUT_S;
   logic [15:0] cfg_display_ms  = RST_DISPLAY_MS;

   // predictor copy of the lock state
   logic [7:0]  entry_chars [CODE_LEN_MAX];
   status_type  model_status = ST_CLOSED;
   logic        model_prior  = 1'b1;
   logic [5:0]  model_wrong  = '0;
   logic [18:0] model_timer  = '0;

   rsp_item_type expected_rsp [$];
   int  fail_count       = 0;
   int  cycle_count      = 0;
   int  useful_words     = 0;
   int  rsp_hold_request = 0;
   bit  sender_idling    = 1'b1;
   bit  receiver_idling  = 1'b1;

   keypad_code_lock #(
      .CODE_MAX_LEN(CODE_LEN_MAX)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      foreach (entry_chars[i]) entry_chars[i] = FILL_CHAR;
   end

   function automatic int eff_code_len();
      int n;
      n = cfg_code_length;
      if (n < 1) n = 1;
      if (n > CODE_LEN_MAX) n = CODE_LEN_MAX;
      return n;
   endfunction

   // advances the lock state by one word and returns the status word it causes
   function automatic rsp_item_type step_lock(input op_type op, input logic [7:0] key);
      int           n;
      bit           match;
      event_type    ev;
      rsp_item_type r;
      n  = eff_code_len();
      ev = EV_NONE;
      if (op == OP_KEY) begin
         if (model_status == ST_OPEN || model_status == ST_CLOSED) begin
            if (key != KEY_VALIDATE) begin
               for (int i = 0; i + 1 < n; i++) entry_chars[i] = entry_chars[i + 1];
               entry_chars[n - 1] = key;
               ev = EV_KEY;
            end else begin
               match = 1'b1;
               for (int i = 0; i < n; i++) begin
                  if (entry_chars[i] != cfg_code_value[8 * i +: 8]) match = 1'b0;
               end
               foreach (entry_chars[i]) entry_chars[i] = FILL_CHAR;
               if (match) begin
                  model_status = (model_status == ST_OPEN) ? ST_CLOSED : ST_OPEN;
                  model_wrong  = '0;
                  ev = EV_CORRECT;
               end else begin
                  if (model_wrong < WRONG_MAX) model_wrong++;
                  model_prior  = model_status[0];
                  model_status = ST_ERROR;
                  model_timer  = '0;
                  ev = EV_WRONG;
               end
            end
         end
      end else if (model_status == ST_ERROR) begin
         model_timer++;
         if (model_timer >= cfg_display_ms) begin
            model_timer = '0;
            if (model_wrong >= cfg_max_errors) model_status = ST_LOCKED;
            else model_status = status_type'({1'b0, model_prior});
         end
      end else if (model_status == ST_LOCKED) begin
         model_timer++;
         if (int'(model_timer) >= int'(cfg_lockout_s) * int'(TICKS_PER_SECOND)) begin
            model_timer  = '0;
            model_status = status_type'({1'b0, model_prior});
            model_wrong  = '0;
         end
      end
      r.lock_status = model_status;
      r.error_count = model_wrong;
      r.event_res   = ev;
      return r;
   endfunction

   function automatic logic [7:0] keypad_char();
      string keys = "0123456789*ABCD";
      return keys[$urandom_range(0, keys.len() - 1)];
   endfunction

   task automatic send_word(input op_type op, input logic [7:0] key);
      while (sender_idling && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= key;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // keys during error display or lockout do nothing
      if (!(op == OP_KEY && (model_status == ST_ERROR || model_status == ST_LOCKED)))
         useful_words++;
      expected_rsp.push_back(step_lock(op, key));
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_word(OP_TICK, 8'($urandom_range(0, 255)));
   endtask

   // types chars byte 0 first
   task automatic send_keys(input logic [63:0] chars, input int count);
      for (int i = 0; i < count; i++) send_word(OP_KEY, chars[8 * i +: 8]);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [63:0] value);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_CODE_LENGTH: cfg_code_length = value[3:0];
         REG_CODE_VALUE:  cfg_code_value  = value;
         REG_MAX_ERRORS:  cfg_max_errors  = value[5:0];
         REG_LOCKOUT_S:   cfg_lockout_s   = value[8:0];
         REG_DISPLAY_MS:  cfg_display_ms  = value[15:0];
         default: ;
      endcase
   endtask

   task automatic check_result();
      rsp_item_type got;
      rsp_item_type want;
      got = rsp_item_type'(rsp_tdata[9:0]);
      if (expected_rsp.size() == 0) begin
         $error("status word with nothing expected: %h", rsp_tdata);
         fail_count++;
      end else begin
         want = expected_rsp.pop_front();
         if (got.lock_status !== want.lock_status) begin
            $error("lock_status: expected %0d, got %0d", want.lock_status, got.lock_status);
            fail_count++;
         end
         if (got.error_count !== want.error_count) begin
            $error("error_count: expected %0d, got %0d", want.error_count, got.error_count);
            fail_count++;
         end
         if (got.event_res !== want.event_res) begin
            $error("event_res: expected %0d, got %0d", want.event_res, got.event_res);
            fail_count++;
         end
         if (rsp_tdata[15:10] !== 6'd0) begin
            $error("tdata padding: expected 0, got %h", rsp_tdata[15:10]);
            fail_count++;
         end
      end
   endtask

   // receiver: checks each word, then picks next cycle's tready
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_result();
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_hold_request > 0) begin
            hold_left = rsp_hold_request - 1;
            rsp_hold_request = 0;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(receiver_idling && $urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // reset registers: code of four zero bytes, display 1100 ms
   task automatic test_reset_defaults();
      send_word(OP_TICK, 8'h00);
      send_word(OP_KEY, KEY_VALIDATE);
      send_word(OP_KEY, "5");
      // display still running well short of its reset length, then cut short
      send_ticks(20);
      csr_write(REG_DISPLAY_MS, 64'd21);
      send_ticks(1);
      send_keys(64'h0, 4);
      send_word(OP_KEY, KEY_VALIDATE);
   endtask

   task automatic test_code_entry();
      csr_write(REG_DISPLAY_MS, 64'd2);
      csr_write(REG_CODE_VALUE, 64'h3433_3231);
      csr_write(REG_CODE_LENGTH, 64'd4);
      send_keys(64'h3433_3231, 4);
      send_word(OP_KEY, KEY_VALIDATE);
      // extra leading keys shift out
      send_word(OP_KEY, 8'h00);
      send_word(OP_KEY, 8'hFF);
      send_keys(64'h3433_3231, 4);
      send_word(OP_KEY, KEY_VALIDATE);
      send_word(OP_TICK, 8'hFF);
      send_word(OP_KEY, KEY_VALIDATE);
      send_ticks(2);
   endtask

   task automatic test_code_length_limits();
      csr_write(REG_CODE_VALUE, 64'hFFFF_FFFF_FFFF_FF41);
      csr_write(REG_CODE_LENGTH, 64'd0);
      send_word(OP_KEY, "Z");
      send_word(OP_KEY, "A");
      send_word(OP_KEY, KEY_VALIDATE);
      csr_write(REG_CODE_VALUE, '1);
      csr_write(REG_CODE_LENGTH, 64'd15);
      send_keys('1, 8);
      send_word(OP_KEY, KEY_VALIDATE);
      csr_write(REG_CODE_LENGTH, 64'd9);
      send_keys('1, 7);
      send_word(OP_KEY, KEY_VALIDATE);
      send_ticks(2);
   endtask

   // the entry row keeps its contents across a length change
   task automatic test_length_change();
      csr_write(REG_CODE_VALUE, 64'h7878_3231);
      csr_write(REG_CODE_LENGTH, 64'd2);
      send_keys(64'h3231, 2);
      csr_write(REG_CODE_LENGTH, 64'd4);
      send_word(OP_KEY, KEY_VALIDATE);
      send_keys(64'h3231, 2);
      csr_write(REG_CODE_LENGTH, 64'd2);
      send_word(OP_KEY, KEY_VALIDATE);
      send_ticks(2);
   endtask

   task automatic test_zero_timers();
      csr_write(REG_DISPLAY_MS, 64'd0);
      csr_write(REG_LOCKOUT_S, 64'd0);
      csr_write(REG_MAX_ERRORS, 64'd0);
      send_word(OP_KEY, KEY_VALIDATE);
      send_word(OP_KEY, "7");
      send_word(OP_TICK, 8'h00);
      send_word(OP_KEY, KEY_VALIDATE);
      send_ticks(2);
   endtask

   task automatic test_lockout_timing();
      csr_write(REG_MAX_ERRORS, 64'd2);
      csr_write(REG_DISPLAY_MS, 64'd1);
      csr_write(REG_LOCKOUT_S, 64'd1);
      repeat (2) begin
         send_word(OP_KEY, KEY_VALIDATE);
         send_word(OP_TICK, 8'h00);
      end
      send_word(OP_KEY, "9");
      // one second outlasts these ticks; a zero length then ends it on the next
      send_ticks(40);
      csr_write(REG_LOCKOUT_S, 64'd0);
      send_ticks(2);
   endtask

   // error count climbs to the top of its field before lockout
   task automatic test_wrong_count_ceiling();
      csr_write(REG_MAX_ERRORS, 64'(WRONG_MAX));
      csr_write(REG_DISPLAY_MS, 64'd1);
      csr_write(REG_LOCKOUT_S, 64'd0);
      repeat (int'(WRONG_MAX)) begin
         send_word(OP_KEY, KEY_VALIDATE);
         send_word(OP_TICK, 8'h00);
      end
      send_ticks(2);
   endtask

   task automatic test_long_display();
      csr_write(REG_MAX_ERRORS, 64'd50);
      csr_write(REG_LOCKOUT_S, 64'd300);
      csr_write(REG_DISPLAY_MS, 64'hFFFF);
      send_word(OP_KEY, KEY_VALIDATE);
      send_ticks(16);
      // a shorter length written mid-display takes effect at once
      csr_write(REG_DISPLAY_MS, 64'd5);
      send_ticks(2);
   endtask

   task automatic test_back_pressure();
      int n;
      csr_write(REG_DISPLAY_MS, 64'd1);
      sender_idling = 1'b0;
      rsp_hold_request = 64;
      for (n = 0; n < 40; n++) begin
         if (n % 9 == 8) send_word(OP_KEY, KEY_VALIDATE);
         else send_word(op_type'($urandom_range(0, 1)), keypad_char());
      end
      sender_idling = 1'b1;
   endtask

   task automatic test_random_traffic();
      int          start;
      int          pick;
      int          r;
      logic [63:0] code;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         r = $urandom_range(0, 9);
         if (phase == 0) csr_write(REG_CODE_LENGTH, 64'd4);
         else if (r == 0) csr_write(REG_CODE_LENGTH, 64'($urandom_range(0, 15)));
         else csr_write(REG_CODE_LENGTH, 64'($urandom_range(1, 8)));
         if (phase == 3) begin
            code = {$urandom, $urandom};
         end else begin
            for (int i = 0; i < 8; i++) code[8 * i +: 8] = keypad_char();
         end
         csr_write(REG_CODE_VALUE, code);
         csr_write(REG_MAX_ERRORS, 64'($urandom_range(0, 4)));
         csr_write(REG_LOCKOUT_S, 64'd0);
         csr_write(REG_DISPLAY_MS, 64'($urandom_range(0, 6)));
         sender_idling   = (phase != 2);
         receiver_idling = (phase != 2);
         start = useful_words;
         while (useful_words - start < RANDOM_WORDS / RANDOM_PHASES) begin
            if (model_status == ST_ERROR || model_status == ST_LOCKED) begin
               if ($urandom_range(9) == 0) send_word(OP_KEY, 8'($urandom_range(0, 255)));
               else send_word(OP_TICK, 8'($urandom_range(0, 255)));
            end else begin
               pick = $urandom_range(99);
               if (pick < 45) begin
                  repeat ($urandom_range(0, 2)) send_word(OP_KEY, keypad_char());
                  send_keys(cfg_code_value, eff_code_len());
                  send_word(OP_KEY, KEY_VALIDATE);
               end else if (pick < 70) begin
                  repeat ($urandom_range(1, 8)) send_word(OP_KEY, keypad_char());
                  send_word(OP_KEY, KEY_VALIDATE);
               end else if (pick < 85) begin
                  repeat ($urandom_range(1, 4))
                     send_word(op_type'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
               end else begin
                  send_ticks($urandom_range(1, 3));
               end
            end
         end
      end
      sender_idling   = 1'b1;
      receiver_idling = 1'b1;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_code_entry();
      test_code_length_limits();
      test_length_change();
      test_zero_timers();
      test_lockout_timing();
      test_wrong_count_ceiling();
      test_long_display();
      test_back_pressure();
      test_random_traffic();
      wait_drained();
      repeat (4) @(posedge clock);
      if (fail_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
